>>> rtl/utsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utsc_pkg
// Shared types and constants for the second-count to calendar converter.
// ----------------------------------------------------------------------------
package utsc_pkg;

    localparam int SEC_W   = 32;
    localparam int FLAG_W  = 8;
    localparam int FRACI_W = 16;
    localparam int CFG_W   = 32;
    localparam int TZ_W    = 12;
    localparam int CIDX_W  = 1;

    localparam int YEAR_W  = 12;
    localparam int MON_W   = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SECO_W  = 6;
    localparam int FRACO_W = 14;

    // Elapsed-year counter width; covers the whole range of the year limit.
    localparam int YR_W    = 8;
    localparam int DAYS_W  = 16;
    localparam int QUO_W   = 16;
    localparam int DVS_W   = 17;

    // Constant divider: the dividend, with the divisor's power-of-two factor
    // shifted out, is multiplied by a rounded-up reciprocal of the odd part
    // and the quotient is taken from the upper product bits.
    localparam int STEP_W  = 2;
    localparam int MULX_W  = 25;
    localparam int RCP_W   = 26;
    localparam int PROD_W  = MULX_W + RCP_W;

    localparam logic [CIDX_W-1:0] CFG_EPOCH_BASE = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_TZ_SHIFT   = 1'b1;

    localparam logic [CFG_W-1:0] EPOCH_BASE_RST = 32'd946684800;

    localparam logic [DVS_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [DVS_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [DVS_W-1:0] SECS_PER_MIN  = 17'd60;
    localparam logic [DVS_W-1:0] DATE_WRAP     = 17'd31;

    // Reciprocals of 675 (2^35), 225 (2^21), 15 (2^14) and 31 (2^21).
    localparam logic [RCP_W-1:0] RCP_DAY  = 26'd50903317;
    localparam logic [RCP_W-1:0] RCP_HOUR = 26'd9321;
    localparam logic [RCP_W-1:0] RCP_MIN  = 26'd1093;
    localparam logic [RCP_W-1:0] RCP_DATE = 26'd67651;

    // Divider phases, counted down: multiply, quotient, remainder.
    localparam logic [STEP_W-1:0] DIV_STEP_MUL = 2'd2;
    localparam logic [STEP_W-1:0] DIV_STEP_QUO = 2'd1;
    localparam logic [STEP_W-1:0] DIV_STEP_REM = 2'd0;

    localparam int LEAP_BIT = 7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_THRESH,
        OP_ELAPSED,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_WALK_START,
        OP_YEAR_STEP,
        OP_MONTH_START,
        OP_MONTH_STEP,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        DSEL_DAY,
        DSEL_HOUR,
        DSEL_MIN,
        DSEL_DATE
    } dsel_t;

    typedef struct packed {
        op_t   op;
        dsel_t dsel;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic year_done;
        logic month_done;
        logic date_big;
    } sts_t;

endpackage

>>> rtl/utsc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utsc_dp
// Datapath: configuration registers, offset arithmetic, a shared
// reciprocal-multiply constant divider and the year and month walk registers.
// ----------------------------------------------------------------------------
module utsc_dp
    import utsc_pkg::*;
#(
    parameter int MAX_YEARS = 150
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic [SEC_W-1:0]    utc_seconds,
    input  logic [FLAG_W-1:0]   quality_flags,
    input  logic [FRACI_W-1:0]  fraction_100us,
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic [YEAR_W-1:0]   year,
    output logic [MON_W-1:0]    month,
    output logic [DAY_W-1:0]    day_of_month,
    output logic [HOUR_W-1:0]   hour,
    output logic [MIN_W-1:0]    minute,
    output logic [SECO_W-1:0]   second,
    output logic [FRACO_W-1:0]  fraction_out
);

    function automatic logic [FRACO_W-1:0] frac_mod(input logic [FRACI_W-1:0] f);
        logic [FRACI_W-1:0] r;
        begin
            r = f;
            if (r >= 16'd40000)
            begin
                r = r - 16'd40000;
            end
            if (r >= 16'd20000)
            begin
                r = r - 16'd20000;
            end
            if (r >= 16'd10000)
            begin
                r = r - 16'd10000;
            end
            return r[FRACO_W-1:0];
        end
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        begin
            case (m)
                4'd2:    return leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
                default: return 5'd31;
            endcase
        end
    endfunction

    logic [CFG_W-1:0]   base_reg;
    logic [TZ_W-1:0]    tz_reg;
    logic [SEC_W-1:0]   utc_reg;
    logic               leap_reg;
    logic [FRACO_W-1:0] frac_reg;
    logic [SEC_W-1:0]   shift_reg;
    logic [SEC_W-1:0]   thr_reg;
    logic [SEC_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [PROD_W-1:0]  prod_reg;
    dsel_t              dsel_reg;
    logic [DAYS_W-1:0]  days_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [MIN_W-1:0]   min_reg;
    logic [SECO_W-1:0]  sec_reg;
    logic [YR_W-1:0]    yr_reg;
    logic [MON_W-1:0]   mon_reg;

    logic [SEC_W-1:0]       tz_ext;
    logic [SEC_W-1:0]       shift_next;
    logic [SEC_W:0]         elapsed;
    logic [DVS_W-1:0]       dvs;
    logic [RCP_W-1:0]       rcp;
    logic [MULX_W-1:0]      mul_x;
    logic [QUO_W-1:0]       quo_next;
    logic [QUO_W+DVS_W-1:0] qd;
    logic [8:0]             ylen;
    logic [DAY_W-1:0]       mlen;
    logic [YEAR_W-1:0]      year_sum;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= EPOCH_BASE_RST;
            tz_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EPOCH_BASE: base_reg <= cfg_data;
                CFG_TZ_SHIFT:   tz_reg   <= cfg_data[TZ_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        tz_ext     = {{(SEC_W-TZ_W){tz_reg[TZ_W-1]}}, tz_reg};
        // Minutes times sixty as (x * 64) - (x * 4), wrapping mod 2^32.
        shift_next = (tz_ext << 6) - (tz_ext << 2);
        elapsed    = {1'b0, utc_reg} - {1'b0, thr_reg};

        // The day wrap dividend is at most one more than the day count, so
        // sixteen bits hold it.
        case (dsel_reg)
            DSEL_DAY:
            begin
                dvs      = SECS_PER_DAY;
                rcp      = RCP_DAY;
                mul_x    = rem_reg[SEC_W-1:7];
                quo_next = prod_reg[50:35];
            end
            DSEL_HOUR:
            begin
                dvs      = SECS_PER_HOUR;
                rcp      = RCP_HOUR;
                mul_x    = MULX_W'(rem_reg[16:4]);
                quo_next = prod_reg[36:21];
            end
            DSEL_MIN:
            begin
                dvs      = SECS_PER_MIN;
                rcp      = RCP_MIN;
                mul_x    = MULX_W'(rem_reg[11:2]);
                quo_next = prod_reg[29:14];
            end
            default:
            begin
                dvs      = DATE_WRAP;
                rcp      = RCP_DATE;
                mul_x    = MULX_W'(rem_reg[15:0]);
                quo_next = prod_reg[36:21];
            end
        endcase
        qd = quo_reg * dvs;

        ylen = (yr_reg[1:0] == 2'b00) ? 9'd366 : 9'd365;
        mlen = month_len(mon_reg, yr_reg[1:0] == 2'b00);

        sts.div_last   = (step_reg == DIV_STEP_REM);
        sts.year_done  = (yr_reg == YR_W'(MAX_YEARS)) || (days_reg < DAYS_W'(ylen));
        sts.month_done = (mon_reg == 4'd13) || (days_reg < DAYS_W'(mlen));
        sts.date_big   = (days_reg >= 16'd31);

        year_sum = YEAR_W'(yr_reg) + 12'd2000;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                utc_reg   <= utc_seconds;
                leap_reg  <= quality_flags[LEAP_BIT];
                frac_reg  <= frac_mod(fraction_100us);
                shift_reg <= shift_next;
            end
            OP_THRESH:
            begin
                thr_reg <= base_reg - shift_reg;
            end
            OP_ELAPSED:
            begin
                // A count at or below the threshold converts as zero.
                rem_reg <= elapsed[SEC_W] || (elapsed[SEC_W-1:0] == '0) ?
                           '0 : elapsed[SEC_W-1:0];
            end
            OP_DIV_START:
            begin
                quo_reg  <= '0;
                dsel_reg <= cmd.dsel;
                step_reg <= DIV_STEP_MUL;
                case (cmd.dsel)
                    DSEL_DAY:
                    begin
                        rem_reg <= rem_reg - SEC_W'(leap_reg);
                    end
                    DSEL_HOUR:
                    begin
                        days_reg <= quo_reg;
                    end
                    DSEL_MIN:
                    begin
                        hour_reg <= quo_reg[HOUR_W-1:0];
                    end
                    default:
                    begin
                        rem_reg <= SEC_W'(days_reg) + 32'd1;
                    end
                endcase
            end
            OP_DIV_STEP:
            begin
                case (step_reg)
                    DIV_STEP_MUL: prod_reg <= mul_x * rcp;
                    DIV_STEP_QUO: quo_reg  <= quo_next;
                    DIV_STEP_REM: rem_reg  <= rem_reg - qd[SEC_W-1:0];
                    default:      ;
                endcase
                step_reg <= step_reg - 1'b1;
            end
            OP_WALK_START:
            begin
                min_reg <= quo_reg[MIN_W-1:0];
                sec_reg <= rem_reg[SECO_W-1:0] + SECO_W'(leap_reg);
                yr_reg  <= '0;
            end
            OP_YEAR_STEP:
            begin
                if (!sts.year_done)
                begin
                    days_reg <= days_reg - DAYS_W'(ylen);
                    yr_reg   <= yr_reg + 1'b1;
                end
            end
            OP_MONTH_START:
            begin
                mon_reg <= 4'd1;
            end
            OP_MONTH_STEP:
            begin
                if (!sts.month_done)
                begin
                    days_reg <= days_reg - DAYS_W'(mlen);
                    mon_reg  <= mon_reg + 1'b1;
                end
            end
            OP_FINISH:
            begin
                year         <= (year_sum >= 12'd2100) ? year_sum - 12'd2100 : year_sum;
                month        <= (mon_reg == 4'd13) ? 4'd1 : mon_reg;
                day_of_month <= sts.date_big ? rem_reg[DAY_W-1:0] :
                                DAY_W'(days_reg + 16'd1);
                hour         <= hour_reg;
                minute       <= min_reg;
                second       <= sec_reg;
                fraction_out <= frac_reg;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/utsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utsc_ctrl
// Controller: sequences the datapath through one conversion and owns the
// input stall and the output valid flag.
// ----------------------------------------------------------------------------
module utsc_ctrl
    import utsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_THRESH,
        S_ELAPSED,
        S_DAY_START,
        S_DIV_DAY,
        S_HOUR_START,
        S_DIV_HOUR,
        S_MIN_START,
        S_DIV_MIN,
        S_WALK_START,
        S_YEAR,
        S_MONTH_START,
        S_MONTH,
        S_DATE_START,
        S_DIV_DATE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        cmd.dsel       = DSEL_DAY;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_THRESH;
                end
            end
            S_THRESH:
            begin
                cmd.op     = OP_THRESH;
                state_next = S_ELAPSED;
            end
            S_ELAPSED:
            begin
                cmd.op     = OP_ELAPSED;
                state_next = S_DAY_START;
            end
            S_DAY_START:
            begin
                cmd.op     = OP_DIV_START;
                cmd.dsel   = DSEL_DAY;
                state_next = S_DIV_DAY;
            end
            S_DIV_DAY:
            begin
                cmd.op = OP_DIV_STEP;
                if (sts.div_last)
                begin
                    state_next = S_HOUR_START;
                end
            end
            S_HOUR_START:
            begin
                cmd.op     = OP_DIV_START;
                cmd.dsel   = DSEL_HOUR;
                state_next = S_DIV_HOUR;
            end
            S_DIV_HOUR:
            begin
                cmd.op = OP_DIV_STEP;
                if (sts.div_last)
                begin
                    state_next = S_MIN_START;
                end
            end
            S_MIN_START:
            begin
                cmd.op     = OP_DIV_START;
                cmd.dsel   = DSEL_MIN;
                state_next = S_DIV_MIN;
            end
            S_DIV_MIN:
            begin
                cmd.op = OP_DIV_STEP;
                if (sts.div_last)
                begin
                    state_next = S_WALK_START;
                end
            end
            S_WALK_START:
            begin
                cmd.op     = OP_WALK_START;
                state_next = S_YEAR;
            end
            S_YEAR:
            begin
                cmd.op = OP_YEAR_STEP;
                if (sts.year_done)
                begin
                    state_next = S_MONTH_START;
                end
            end
            S_MONTH_START:
            begin
                cmd.op     = OP_MONTH_START;
                state_next = S_MONTH;
            end
            S_MONTH:
            begin
                cmd.op = OP_MONTH_STEP;
                if (sts.month_done)
                begin
                    state_next = sts.date_big ? S_DATE_START : S_DONE;
                end
            end
            S_DATE_START:
            begin
                cmd.op     = OP_DIV_START;
                cmd.dsel   = DSEL_DATE;
                state_next = S_DIV_DATE;
            end
            S_DIV_DATE:
            begin
                cmd.op = OP_DIV_STEP;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/utc_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_seconds_to_calendar_top
// Converts a 32-bit UTC second count, shifted by a time-zone offset and
// measured from a programmable epoch base, into calendar date and time.
// ----------------------------------------------------------------------------
// The year walk runs once per elapsed year until MAX_YEARS is reached, the month
// walk once per month passed until month 13, and the day wrap runs only when the
// day count needs wrapping. One transaction is in flight at a time; the next is
// taken in the idle state that follows the registered result, and the year walk
// dominates the conversion time.
// Reset clears the controller and loads 2000-01-01 and a zero offset.
// ----------------------------------------------------------------------------
module utc_seconds_to_calendar_top
    import utsc_pkg::*;
#(
    // Limit of the year walk; the year counter is sized for up to 255.
    parameter int MAX_YEARS = 150
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration write port; the user must write only while the block is idle (not enforced).
    input  logic                cfg_we,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    // Input transaction channel.
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SEC_W-1:0]    utc_seconds,
    input  logic [FLAG_W-1:0]   quality_flags,
    input  logic [FRACI_W-1:0]  fraction_100us,
    // Result transaction channel.
    output logic                out_valid,
    input  logic                out_stall,
    output logic [YEAR_W-1:0]   year,
    output logic [MON_W-1:0]    month,
    output logic [DAY_W-1:0]    day_of_month,
    output logic [HOUR_W-1:0]   hour,
    output logic [MIN_W-1:0]    minute,
    output logic [SECO_W-1:0]   second,
    output logic [FRACO_W-1:0]  fraction_out
);

    // The controller issues one command per cycle and the datapath answers
    // with the status of its divider and of the year and month walks.
    cmd_t cmd;
    sts_t sts;

    // The controller accepts a new transaction only in its idle state. The
    // result sits in an output register, so the next transaction can be
    // taken while the previous result is still waiting downstream.
    utsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, a constant divider that works by
    // reciprocal multiplication in its multiply, quotient and remainder phases
    // (used for days, hours, minutes and the day wrap), and a year
    // and month walk that subtracts one length per cycle.
    utsc_dp #(
        .MAX_YEARS (MAX_YEARS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .utc_seconds    (utc_seconds),
        .quality_flags  (quality_flags),
        .fraction_100us (fraction_100us),
        .cmd            (cmd),
        .sts            (sts),
        .year           (year),
        .month          (month),
        .day_of_month   (day_of_month),
        .hour           (hour),
        .minute         (minute),
        .second         (second),
        .fraction_out   (fraction_out)
    );

endmodule
